// ===== src/nncs_pkg.sv =====
// Shared types and constants of the nearest-neighbour crop scaler.
`default_nettype none
package nncs_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_IMAGE_WIDTH  = 3'd0,
		CFG_IMAGE_HEIGHT = 3'd1,
		CFG_CROP_LEFT    = 3'd2,
		CFG_CROP_TOP     = 3'd3,
		CFG_CROP_WIDTH   = 3'd4,
		CFG_CROP_HEIGHT  = 3'd5,
		CFG_OUT_WIDTH    = 3'd6,
		CFG_OUT_HEIGHT   = 3'd7
	} cfg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int DIM_W      = 9;   // source image and crop sizes
	localparam int OFS_W      = 8;   // crop offsets
	localparam int OUT_W      = 13;  // output frame sizes
	localparam int CNT_POS_W  = 12;  // output column and row counters
	localparam int COORD_W    = 10;  // mapped source coordinate
	localparam int PIX_W      = 24;

	localparam logic [OUT_W-1:0] OUT_LIMIT = 13'd4096;

	// divider: numerator 2*pos*span + n, denominator 2*n, quotient below 2**QUO_W
	localparam int PROD_W = CNT_POS_W + DIM_W;
	localparam int NUM_W  = PROD_W + 2;
	localparam int DEN_W  = OUT_W + 1;
	localparam int QUO_W  = 10;
	localparam int STEP_W = 4;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] numer;
		logic [DEN_W-1:0] denom;
	} div_req_t;

endpackage
`default_nettype wire

// ===== src/nearest_neighbor_crop_scaler_unit.sv =====
// Nearest-neighbour crop scaler: frame store loader and scaled pixel fetch.
// Load items are written to the store in the cycle they are accepted; one per cycle while
// no fetch is in progress. A fetch item goes through multiply, divider load, ten divide steps
// on both axes at once, a completion check, coordinate check, store read and output load.
// The result waits in an output register; the next item is taken the cycle after it loads,
// so one fetch ends before the next starts; the load waits while a full output is not taken.
`default_nettype none
module nearest_neighbor_crop_scaler_unit #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [nncs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [nncs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            command,
	input  wire logic [7:0]                      red_in,
	input  wire logic [7:0]                      green_in,
	input  wire logic [7:0]                      blue_in,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [7:0]                      red_out,
	output logic      [7:0]                      green_out,
	output logic      [7:0]                      blue_out,
	output logic                                 source_valid,
	output logic                                 frame_last
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	localparam int DIM_W = nncs_pkg::DIM_W;
	localparam int OFS_W = nncs_pkg::OFS_W;
	localparam int OUT_W = nncs_pkg::OUT_W;
	localparam int PW    = nncs_pkg::CNT_POS_W;
	localparam int CDW   = nncs_pkg::COORD_W;
	localparam int PRW   = nncs_pkg::PROD_W;
	localparam int NW    = nncs_pkg::NUM_W;
	localparam int QW    = nncs_pkg::QUO_W;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MUL   = 7'b0000010,
		ST_START = 7'b0000100,
		ST_DIV   = 7'b0001000,
		ST_COORD = 7'b0010000,
		ST_READ  = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// configuration
	logic [DIM_W-1:0] image_width_q;
	logic [DIM_W-1:0] image_height_q;
	logic [OFS_W-1:0] crop_left_q;
	logic [OFS_W-1:0] crop_top_q;
	logic [DIM_W-1:0] crop_width_q;
	logic [DIM_W-1:0] crop_height_q;
	logic [OUT_W-1:0] out_width_q;
	logic [OUT_W-1:0] out_height_q;

	// derived configuration
	logic [DIM_W-1:0] img_w;
	logic [DIM_W-1:0] img_h;
	logic [OUT_W-1:0] ew;
	logic [OUT_W-1:0] eh;
	logic [OFS_W-1:0] dx;
	logic [OFS_W-1:0] dy;
	logic [DIM_W-1:0] cw;
	logic [DIM_W-1:0] ch;

	// scan and load state
	logic [AW-1:0] load_address_q;
	logic [PW-1:0] out_column_q;
	logic [PW-1:0] out_row_q;
	logic [PW-1:0] col;
	logic [PW-1:0] row;
	logic [OUT_W-1:0] col_inc;
	logic [OUT_W-1:0] row_inc;
	logic          pix_last;

	logic in_accept;
	logic fetch_accept;
	logic load_accept;

	// fetch datapath
	logic [PW-1:0]   col_q;
	logic [PW-1:0]   row_q;
	logic            last_q;
	logic [PRW-1:0]  prod_x_q;
	logic [PRW-1:0]  prod_y_q;
	nncs_pkg::div_req_t req_x;
	nncs_pkg::div_req_t req_y;
	logic            busy_x;
	logic            busy_y;
	logic [QW-1:0]   quo_x;
	logic [QW-1:0]   quo_y;
	logic [CDW-1:0]  sx;
	logic [CDW-1:0]  sy;
	logic [CDW-1:0]  sx_q;
	logic [CDW-1:0]  sy_q;
	logic            src_ok_q;
	logic [CDW+DIM_W-1:0] row_base;
	logic [CDW+DIM_W:0]   lin_addr;

	logic                       rd_en;
	logic [AW-1:0]              rd_addr;
	logic [nncs_pkg::PIX_W-1:0] rd_data;

	logic load_out;
	logic out_valid_q;

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 9'd256;
			image_height_q <= 9'd256;
			crop_left_q    <= '0;
			crop_top_q     <= '0;
			crop_width_q   <= '0;
			crop_height_q  <= 9'd256;
			out_width_q    <= 13'd256;
			out_height_q   <= 13'd256;
		end else if (cfg_write) begin
			unique case (cfg_index)
				nncs_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[DIM_W-1:0];
				nncs_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[DIM_W-1:0];
				nncs_pkg::CFG_CROP_LEFT:    crop_left_q    <= cfg_data[OFS_W-1:0];
				nncs_pkg::CFG_CROP_TOP:     crop_top_q     <= cfg_data[OFS_W-1:0];
				nncs_pkg::CFG_CROP_WIDTH:   crop_width_q   <= cfg_data[DIM_W-1:0];
				nncs_pkg::CFG_CROP_HEIGHT:  crop_height_q  <= cfg_data[DIM_W-1:0];
				nncs_pkg::CFG_OUT_WIDTH:    out_width_q    <= cfg_data[OUT_W-1:0];
				nncs_pkg::CFG_OUT_HEIGHT:   out_height_q   <= cfg_data[OUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		img_w = (32'(image_width_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : image_width_q;
		img_h = (32'(image_height_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : image_height_q;
		if (out_width_q == '0) begin
			ew = OUT_W'(1);
		end else if (out_width_q > nncs_pkg::OUT_LIMIT) begin
			ew = nncs_pkg::OUT_LIMIT;
		end else begin
			ew = out_width_q;
		end
		if (out_height_q == '0) begin
			eh = OUT_W'(1);
		end else if (out_height_q > nncs_pkg::OUT_LIMIT) begin
			eh = nncs_pkg::OUT_LIMIT;
		end else begin
			eh = out_height_q;
		end
		// zero crop width: whole image, no offset
		if (crop_width_q == '0) begin
			dx = '0;
			dy = '0;
			cw = img_w;
			ch = img_h;
		end else begin
			dx = crop_left_q;
			dy = crop_top_q;
			cw = crop_width_q;
			ch = crop_height_q;
		end
	end

	// handshake
	assign in_ready     = (state_q == ST_IDLE);
	assign in_accept    = in_valid && in_ready;
	assign fetch_accept = in_accept && command;
	assign load_accept  = in_accept && !command;

	// output scan position; counters left beyond the frame by a resize read as zero
	always_comb begin
		col      = (OUT_W'(out_column_q) < ew) ? out_column_q : '0;
		row      = (OUT_W'(out_row_q) < eh) ? out_row_q : '0;
		col_inc  = OUT_W'(col) + OUT_W'(1);
		row_inc  = OUT_W'(row) + OUT_W'(1);
		pix_last = (col_inc == ew) && (row_inc == eh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_address_q <= '0;
			out_column_q   <= '0;
			out_row_q      <= '0;
		end else begin
			if (load_accept) begin
				load_address_q <= (load_address_q == AW'(DEPTH - 1)) ? '0
					: load_address_q + 1'b1;
			end
			if (fetch_accept) begin
				if (col_inc >= ew) begin
					out_column_q <= '0;
					out_row_q    <= (row_inc >= eh) ? '0 : row_inc[PW-1:0];
				end else begin
					out_column_q <= col_inc[PW-1:0];
					out_row_q    <= row;
				end
			end
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (fetch_accept) state_d = ST_MUL;
			ST_MUL:   state_d = ST_START;
			ST_START: state_d = ST_DIV;
			ST_DIV:   if (!busy_x && !busy_y) state_d = ST_COORD;
			ST_COORD: state_d = ST_READ;
			ST_READ:  state_d = ST_OUT;
			ST_OUT:   if (load_out) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// fetch datapath
	always_ff @(posedge clk) begin
		if (fetch_accept) begin
			col_q  <= col;
			row_q  <= row;
			last_q <= pix_last;
		end
		if (state_q == ST_MUL) begin
			prod_x_q <= col_q * cw;
			prod_y_q <= row_q * ch;
		end
		if (state_q == ST_COORD) begin
			sx_q     <= sx;
			sy_q     <= sy;
			src_ok_q <= (sx < CDW'(img_w)) && (sy < CDW'(img_h));
		end
	end

	// round half up: (2*pos*span + n) / (2*n); the offset adds whole units
	always_comb begin
		req_x.start = (state_q == ST_START);
		req_x.numer = NW'({prod_x_q, 1'b0}) + NW'(ew);
		req_x.denom = {ew, 1'b0};
		req_y.start = (state_q == ST_START);
		req_y.numer = NW'({prod_y_q, 1'b0}) + NW'(eh);
		req_y.denom = {eh, 1'b0};
	end

	nncs_coord_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_x),
		.busy     (busy_x),
		.quotient (quo_x)
	);

	nncs_coord_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_y),
		.busy     (busy_y),
		.quotient (quo_y)
	);

	assign sx = CDW'(dx) + CDW'(quo_x);
	assign sy = CDW'(dy) + CDW'(quo_y);

	// an in-range coordinate always lands inside the store
	assign row_base = sy_q * img_w;
	assign lin_addr = (CDW+DIM_W+1)'(row_base) + (CDW+DIM_W+1)'(sx_q);
	assign rd_en    = (state_q == ST_READ) && src_ok_q;
	assign rd_addr  = AW'(lin_addr);

	nncs_frame_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (load_accept),
		.wr_addr (load_address_q),
		.wr_data ({red_in, green_in, blue_in}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// output register
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			red_out      <= src_ok_q ? rd_data[23:16] : '0;
			green_out    <= src_ok_q ? rd_data[15:8] : '0;
			blue_out     <= src_ok_q ? rd_data[7:0] : '0;
			source_valid <= src_ok_q;
			frame_last   <= last_q;
		end
	end

	assign out_valid = out_valid_q;

	// both axes run the same number of divide steps
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (busy_x == busy_y))
		else $error("divider lanes out of step");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_accept |=> !in_ready)
		else $error("item taken while a fetch is in progress");

	a_black_when_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !source_valid) |->
		(red_out == '0 && green_out == '0 && blue_out == '0))
		else $error("pixel outside image not black");

	a_wrap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(fetch_accept && pix_last) |=> (out_column_q == '0 && out_row_q == '0))
		else $error("scan did not wrap after final pixel");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_valid_q && !out_ready) |=> (state_q == ST_OUT))
		else $error("result dropped while output stalled");

endmodule
`default_nettype wire

// ===== src/nncs_frame_store.sv =====
// Frame store: single write port, registered read port.
`default_nettype none
module nncs_frame_store #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [AW-1:0]              wr_addr,
	input  wire logic [nncs_pkg::PIX_W-1:0] wr_data,
	input  wire logic                       rd_en,
	input  wire logic [AW-1:0]              rd_addr,
	output logic      [nncs_pkg::PIX_W-1:0] rd_data
);

	logic [nncs_pkg::PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== src/nncs_coord_div.sv =====
// Restoring divider, one quotient bit per cycle, for coordinate mapping.
`default_nettype none
module nncs_coord_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire nncs_pkg::div_req_t         req,
	output logic                            busy,
	output logic      [nncs_pkg::QUO_W-1:0] quotient
);

	localparam int DW = nncs_pkg::DEN_W;
	localparam int QW = nncs_pkg::QUO_W;
	localparam int NW = nncs_pkg::NUM_W;

	logic [DW-1:0]               rem_q;
	logic [DW-1:0]               den_q;
	logic [QW-1:0]               sh_q;   // numerator bits out, quotient bits in
	logic [nncs_pkg::STEP_W-1:0] step_q;
	logic                        busy_q;
	logic [DW:0]                 trial;
	logic [DW:0]                 diff;
	logic                        fits;

	assign trial = {rem_q, sh_q[QW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= nncs_pkg::STEP_W'(QW);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == nncs_pkg::STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// the quotient is known to fit QW bits, so the top bits seed the remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= DW'(req.numer[NW-1:QW]);
			sh_q  <= req.numer[QW-1:0];
			den_q <= req.denom;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			sh_q  <= {sh_q[QW-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = sh_q;

endmodule
`default_nettype wire

// ===== bench/nncs_test_pkg.sv =====
// Command codes shared by the crop scaler stimulus and checker.
`timescale 1ns / 1ps
package nncs_test_pkg;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_FETCH = 1'b1
	} pixel_cmd_t;

endpackage

// ===== bench/nncs_pixel_checker.sv =====
// Scaled pixel predictor and result checker for the crop scaler unit.
`timescale 1ns / 1ps
module nncs_pixel_checker #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [nncs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [nncs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	input  wire logic                            in_ready,
	input  wire logic                            command,
	input  wire logic [7:0]                      red_in,
	input  wire logic [7:0]                      green_in,
	input  wire logic [7:0]                      blue_in,
	input  wire logic                            out_valid,
	input  wire logic                            out_ready,
	input  wire logic [7:0]                      red_out,
	input  wire logic [7:0]                      green_out,
	input  wire logic [7:0]                      blue_out,
	input  wire logic                            source_valid,
	input  wire logic                            frame_last,
	output int                                   failures,
	output int                                   pending
);
	import nncs_pkg::*;
	import nncs_test_pkg::*;

	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       source_valid;
		logic       frame_last;
	} scaled_pixel_t;

	logic [PIX_W-1:0] pixel_store [STORE_DEPTH];
	int unsigned      load_ptr;
	int unsigned      out_col;
	int unsigned      out_row;

	logic [DIM_W-1:0] image_w;
	logic [DIM_W-1:0] image_h;
	logic [OFS_W-1:0] crop_x;
	logic [OFS_W-1:0] crop_y;
	logic [DIM_W-1:0] crop_w;
	logic [DIM_W-1:0] crop_h;
	logic [OUT_W-1:0] frame_w;
	logic [OUT_W-1:0] frame_h;

	scaled_pixel_t awaited_pixels [$];
	int            fail_count = 0;

	initial failures = 0;
	initial pending = 0;

	// off + pos*span/n, halves rounded up
	function automatic longint unsigned nearest_source(longint unsigned off, longint unsigned pos,
			longint unsigned span, longint unsigned n);
		return (2 * (off * n + pos * span) + n) / (2 * n);
	endfunction

	function automatic scaled_pixel_t fetch_pixel();
		int unsigned     w, h, ew, eh, dx, dy, cw, ch, col, row;
		longint unsigned sx, sy;
		logic [PIX_W-1:0] pix;
		scaled_pixel_t   res;
		w  = (image_w > MAX_WIDTH) ? MAX_WIDTH : image_w;
		h  = (image_h > MAX_HEIGHT) ? MAX_HEIGHT : image_h;
		ew = (frame_w == 0) ? 1 : (frame_w > OUT_LIMIT) ? OUT_LIMIT : frame_w;
		eh = (frame_h == 0) ? 1 : (frame_h > OUT_LIMIT) ? OUT_LIMIT : frame_h;
		if (crop_w == 0) begin
			dx = 0;
			dy = 0;
			cw = w;
			ch = h;
		end else begin
			dx = crop_x;
			dy = crop_y;
			cw = crop_w;
			ch = crop_h;
		end
		// counters left beyond a shrunken frame restart at zero
		col = (out_col < ew) ? out_col : 0;
		row = (out_row < eh) ? out_row : 0;
		sx = nearest_source(dx, col, cw, ew);
		sy = nearest_source(dy, row, ch, eh);
		res.source_valid = (sx < w) && (sy < h);
		pix = res.source_valid ? pixel_store[int'(sy * w + sx)] : '0;
		res.red        = pix[23:16];
		res.green      = pix[15:8];
		res.blue       = pix[7:0];
		res.frame_last = (col == ew - 1) && (row == eh - 1);
		if (col + 1 >= ew) begin
			out_col = 0;
			out_row = (row + 1 >= eh) ? 0 : row + 1;
		end else begin
			out_col = col + 1;
			out_row = row;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		scaled_pixel_t seen, want;
		if (!arst_n) begin
			load_ptr = 0;
			out_col  = 0;
			out_row  = 0;
			image_w  = 9'd256;
			image_h  = 9'd256;
			crop_x   = '0;
			crop_y   = '0;
			crop_w   = '0;
			crop_h   = 9'd256;
			frame_w  = 13'd256;
			frame_h  = 13'd256;
			awaited_pixels.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				seen = '{red_out, green_out, blue_out, source_valid, frame_last};
				if (awaited_pixels.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected pixel: r=%02h g=%02h b=%02h valid=%b last=%b",
							seen.red, seen.green, seen.blue, seen.source_valid,
							seen.frame_last);
				end else begin
					want = awaited_pixels.pop_front();
					if (seen.red !== want.red || seen.green !== want.green ||
							seen.blue !== want.blue || seen.source_valid !== want.source_valid ||
							seen.frame_last !== want.frame_last) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"pixel mismatch: expected r=%02h g=%02h b=%02h valid=%b ",
								"last=%b, got r=%02h g=%02h b=%02h valid=%b last=%b"},
								want.red, want.green, want.blue, want.source_valid,
								want.frame_last, seen.red, seen.green, seen.blue,
								seen.source_valid, seen.frame_last);
					end
				end
			end
			if (cfg_write) begin
				case (cfg_idx_t'(cfg_index))
					CFG_IMAGE_WIDTH:  image_w = cfg_data[DIM_W-1:0];
					CFG_IMAGE_HEIGHT: image_h = cfg_data[DIM_W-1:0];
					CFG_CROP_LEFT:    crop_x  = cfg_data[OFS_W-1:0];
					CFG_CROP_TOP:     crop_y  = cfg_data[OFS_W-1:0];
					CFG_CROP_WIDTH:   crop_w  = cfg_data[DIM_W-1:0];
					CFG_CROP_HEIGHT:  crop_h  = cfg_data[DIM_W-1:0];
					CFG_OUT_WIDTH:    frame_w = cfg_data[OUT_W-1:0];
					CFG_OUT_HEIGHT:   frame_h = cfg_data[OUT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (command == CMD_FETCH) begin
					awaited_pixels.push_back(fetch_pixel());
				end else begin
					pixel_store[load_ptr] = {red_in, green_in, blue_in};
					load_ptr = (load_ptr + 1 == STORE_DEPTH) ? 0 : load_ptr + 1;
				end
			end
			pending <= awaited_pixels.size();
		end
		failures <= fail_count;
	end

endmodule

// ===== bench/nearest_neighbor_crop_scaler_unit_test.sv =====
// Stimulus and verdict for the nearest-neighbour crop scaler unit.
`timescale 1ns / 1ps
module nearest_neighbor_crop_scaler_unit_test;
	import nncs_pkg::*;
	import nncs_test_pkg::*;

	localparam int IMG_MAX      = 256;
	localparam int STORE_DEPTH  = IMG_MAX * IMG_MAX;
	localparam int FILL_ITEMS   = 512;
	localparam int RANDOM_ITEMS = 1420;
	localparam int DRAIN_CYCLES = 32;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 2_000_000;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_write    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic                  command      = 1'b0;
	logic [7:0]            red_in       = '0;
	logic [7:0]            green_in     = '0;
	logic [7:0]            blue_in      = '0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic [7:0]            red_out;
	logic [7:0]            green_out;
	logic [7:0]            blue_out;
	logic                  source_valid;
	logic                  frame_last;

	int          failures;
	int          pending;
	int unsigned cycle_count     = 0;
	int unsigned holds_asked     = 0;
	int unsigned holds_taken     = 0;
	int unsigned loaded          = 0;
	bit          receiver_steady = 1'b0;

	always #1 clk = ~clk;

	nearest_neighbor_crop_scaler_unit #(
		.MAX_WIDTH  (IMG_MAX),
		.MAX_HEIGHT (IMG_MAX)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.red_in       (red_in),
		.green_in     (green_in),
		.blue_in      (blue_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red_out      (red_out),
		.green_out    (green_out),
		.blue_out     (blue_out),
		.source_valid (source_valid),
		.frame_last   (frame_last)
	);

	nncs_pixel_checker #(
		.MAX_WIDTH  (IMG_MAX),
		.MAX_HEIGHT (IMG_MAX)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.red_in       (red_in),
		.green_in     (green_in),
		.blue_in      (blue_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red_out      (red_out),
		.green_out    (green_out),
		.blue_out     (blue_out),
		.source_valid (source_valid),
		.frame_last   (frame_last),
		.failures     (failures),
		.pending      (pending)
	);

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int unsigned pick_value(int unsigned small_max, int unsigned field_max,
			int unsigned corner);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 0;
		if (r == 1)
			return field_max;
		if (r == 2)
			return corner;
		if (r < 8)
			return $urandom_range(1, small_max);
		return $urandom_range(0, field_max);
	endfunction

	function automatic int unsigned clamp_dim(int unsigned v);
		return (v > IMG_MAX) ? IMG_MAX : v;
	endfunction

	// valid stays up from one item to the next unless a gap follows
	task automatic offer(input pixel_cmd_t cmd, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		command  <= cmd;
		red_in   <= r;
		green_in <= g;
		blue_in  <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (cmd == CMD_LOAD && loaded < STORE_DEPTH)
			loaded++;
	endtask

	task automatic pause_sender(input int unsigned cycles);
		if (cycles != 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// loads leave no trace in pending, hence the extra drain
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
		@(posedge clk);
	endtask

	task automatic choose_setting(input bit every_reg);
		int unsigned value, img_w, img_h;
		// the image must not reach past the entries loaded so far
		img_w = pick_value(24, 511, IMG_MAX);
		img_h = pick_value(24, 511, IMG_MAX);
		if (clamp_dim(img_w) * clamp_dim(img_h) > loaded)
			img_h = loaded / clamp_dim(img_w);
		write_reg(CFG_IMAGE_WIDTH, img_w);
		write_reg(CFG_IMAGE_HEIGHT, img_h);
		for (int i = 2; i < 8; i++) begin
			case (cfg_idx_t'(i))
				CFG_CROP_LEFT, CFG_CROP_TOP:       value = pick_value(8, 255, 128);
				CFG_CROP_WIDTH:
					value = ($urandom_range(0, 9) < 4) ? 0 : pick_value(24, 511, 256);
				CFG_CROP_HEIGHT:                   value = pick_value(24, 511, 256);
				default:                           value = pick_value(12, 8191, OUT_LIMIT);
			endcase
			if (every_reg || $urandom_range(0, 1) == 1)
				write_reg(cfg_idx_t'(i), value);
		end
		cfg_write <= 1'b0;
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("nearest_neighbor_crop_scaler_unit_test failed");
			$finish;
		end
	end

	// output side: random stalls, plus a long hold-off when asked
	initial begin
		int unsigned stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (holds_taken != holds_asked) begin
				holds_taken++;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = receiver_steady ? 0 : pick_gap();
				if (stall != 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	initial begin
		int unsigned items_sent, phase, load_pct, batch;
		bit          sender_steady, squeeze;
		items_sent = 0;
		phase      = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// black and white in entries 0 and 1, then random pixels for the first rows;
		// every fetch below stays inside the loaded entries
		offer(CMD_LOAD, 8'h00, 8'h00, 8'h00);
		offer(CMD_LOAD, 8'hFF, 8'hFF, 8'hFF);
		for (int i = 2; i < FILL_ITEMS; i++)
			offer(CMD_LOAD, $urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255));

		wait_idle();
		write_reg(CFG_IMAGE_WIDTH, 2);
		write_reg(CFG_IMAGE_HEIGHT, 1);
		write_reg(CFG_CROP_LEFT, 0);
		write_reg(CFG_CROP_TOP, 0);
		write_reg(CFG_CROP_WIDTH, 0);
		write_reg(CFG_CROP_HEIGHT, 256);
		write_reg(CFG_OUT_WIDTH, 2);
		write_reg(CFG_OUT_HEIGHT, 1);
		cfg_write <= 1'b0;
		repeat (3) offer(CMD_FETCH, 8'hFF, 8'h00, 8'hFF);

		// oversized image and output sizes saturate; only row 0 is read
		wait_idle();
		write_reg(CFG_IMAGE_WIDTH, 511);
		write_reg(CFG_IMAGE_HEIGHT, 300);
		write_reg(CFG_OUT_WIDTH, 8191);
		write_reg(CFG_OUT_HEIGHT, 0);
		cfg_write <= 1'b0;
		repeat (3) offer(CMD_FETCH, 8'h00, 8'hFF, 8'h00);

		// crop window off the right edge with zero height
		wait_idle();
		write_reg(CFG_CROP_LEFT, 255);
		write_reg(CFG_CROP_TOP, 1);
		write_reg(CFG_CROP_WIDTH, 5);
		write_reg(CFG_CROP_HEIGHT, 0);
		write_reg(CFG_OUT_WIDTH, 4);
		write_reg(CFG_OUT_HEIGHT, 2);
		cfg_write <= 1'b0;
		repeat (4) offer(CMD_FETCH, 8'h00, 8'h00, 8'h00);

		wait_idle();
		write_reg(CFG_CROP_LEFT, 0);
		write_reg(CFG_CROP_TOP, 0);
		write_reg(CFG_CROP_WIDTH, 256);
		write_reg(CFG_CROP_HEIGHT, 256);
		write_reg(CFG_OUT_WIDTH, 4096);
		write_reg(CFG_OUT_HEIGHT, 4096);
		cfg_write <= 1'b0;
		repeat (4) offer(CMD_FETCH, 8'h00, 8'h00, 8'h00);

		// column counter now lies past the narrower frame
		wait_idle();
		write_reg(CFG_OUT_WIDTH, 3);
		cfg_write <= 1'b0;
		repeat (2) offer(CMD_FETCH, 8'h00, 8'h00, 8'h00);

		while (items_sent < RANDOM_ITEMS) begin
			wait_idle();
			choose_setting(phase == 0);
			squeeze         = (phase == 2);
			sender_steady   = squeeze || $urandom_range(0, 3) == 0;
			receiver_steady = !squeeze && $urandom_range(0, 3) == 0;
			load_pct        = squeeze ? 0 : $urandom_range(0, 30);
			batch           = squeeze ? 120 : $urandom_range(30, 120);
			if (squeeze)
				holds_asked++;
			repeat (batch) begin
				offer(($urandom_range(0, 99) < load_pct) ? CMD_LOAD : CMD_FETCH,
					$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
				items_sent++;
				if (!sender_steady)
					pause_sender(pick_gap());
			end
			phase++;
		end

		wait_idle();
		if (failures == 0)
			$display("nearest_neighbor_crop_scaler_unit_test passed");
		else
			$display("nearest_neighbor_crop_scaler_unit_test failed");
		$finish;
	end

endmodule
